>>> src/vkdi_pkg.sv
package vkdi_pkg;

  localparam int CNT_W = 25;
  localparam int FETCH_W = 24;
  localparam int OUT_W = 12;
  localparam int ERR_W = 3;
  localparam int EPOCH_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_POSITION = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NORMAL = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TEXCOORD = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FULL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXCOORD_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_NORMALS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_TEXCOORDS = 3'd4;

  typedef struct packed {
    logic load;
    logic clear;
    logic sweep;
    logic rd;
    logic next;
    logic resolve;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic failed;
    logic epoch_last;
    logic sweep_last;
    logic slot_live;
    logic slot_match;
    logic out_free;
  } status_t;

endpackage

>>> src/vertex_key_dedup_indexer_top.sv
// A transaction is accepted only while the block is idle, and no new one is taken until the
// previous result has been registered, which waits while a held result is stalled. A lookup
// reads its hash slot and each further linear probe the next one; a transaction answered by
// a sticky error skips the table read. Reset is synchronous and clears all control state,
// then sweeps all 2**($clog2(TABLE_ENTRIES)+1) hash table slots before the first transaction
// is taken; a start of mesh repeats this sweep once every 15 meshes, when the epoch mark wraps.
module vertex_key_dedup_indexer_top #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int SOURCE_INDEX_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_mesh,
  input  logic signed [SOURCE_INDEX_BITS:0] position_index,
  input  logic signed [SOURCE_INDEX_BITS:0] normal_idx,
  input  logic signed [SOURCE_INDEX_BITS:0] texcoord_idx,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vkdi_pkg::OUT_W-1:0]        out_vertex,
  output logic                              is_new,
  output logic [vkdi_pkg::FETCH_W-1:0]      fetch_position,
  output logic [vkdi_pkg::FETCH_W-1:0]      fetch_normal,
  output logic                              normal_is_zero,
  output logic [vkdi_pkg::FETCH_W-1:0]      fetch_texcoord,
  output logic                              texcoord_is_zero,
  output logic [vkdi_pkg::ERR_W-1:0]        error_code,
  input  logic                              cfg_we,
  input  logic [vkdi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vkdi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  vkdi_pkg::cmd_t    cmd;
  vkdi_pkg::status_t status;

  vkdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vkdi_datapath #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .SOURCE_INDEX_BITS (SOURCE_INDEX_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .start_mesh       (start_mesh),
    .position_index   (position_index),
    .normal_idx       (normal_idx),
    .texcoord_idx     (texcoord_idx),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex       (out_vertex),
    .is_new           (is_new),
    .fetch_position   (fetch_position),
    .fetch_normal     (fetch_normal),
    .normal_is_zero   (normal_is_zero),
    .fetch_texcoord   (fetch_texcoord),
    .texcoord_is_zero (texcoord_is_zero),
    .error_code       (error_code)
  );

endmodule

>>> src/vkdi_ctrl.sv
module vkdi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vkdi_pkg::status_t status,
  output vkdi_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_INIT_SWEEP,
    ST_IDLE,
    ST_CLEAR,
    ST_MESH_SWEEP,
    ST_READ,
    ST_CMP,
    ST_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_INIT_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (status.start) begin
          cmd.clear = 1'b1;
          if (status.epoch_last) begin
            state_next = ST_MESH_SWEEP;
          end else begin
            cmd.rd = 1'b1;
            state_next = ST_CMP;
          end
        end else if (status.failed) begin
          state_next = ST_RESP;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_MESH_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.slot_match || !status.slot_live) begin
          cmd.resolve = 1'b1;
          state_next = ST_RESP;
        end else begin
          cmd.rd = 1'b1;
          cmd.next = 1'b1;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_SWEEP;
      in_stall <= 1'b1;
    end else begin
      state <= state_next;
      in_stall <= (state_next != ST_IDLE);
    end
  end

endmodule

>>> src/vkdi_datapath.sv
module vkdi_datapath #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int SOURCE_INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vkdi_pkg::cmd_t                        cmd,
  output vkdi_pkg::status_t                     status,
  input  logic                                  start_mesh,
  input  logic signed [SOURCE_INDEX_BITS:0]     position_index,
  input  logic signed [SOURCE_INDEX_BITS:0]     normal_idx,
  input  logic signed [SOURCE_INDEX_BITS:0]     texcoord_idx,
  input  logic                                  cfg_we,
  input  logic [vkdi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vkdi_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [vkdi_pkg::OUT_W-1:0]            out_vertex,
  output logic                                  is_new,
  output logic [vkdi_pkg::FETCH_W-1:0]          fetch_position,
  output logic [vkdi_pkg::FETCH_W-1:0]          fetch_normal,
  output logic                                  normal_is_zero,
  output logic [vkdi_pkg::FETCH_W-1:0]          fetch_texcoord,
  output logic                                  texcoord_is_zero,
  output logic [vkdi_pkg::ERR_W-1:0]            error_code
);

  localparam int IDX_W = SOURCE_INDEX_BITS + 1;
  localparam int VAL_W = $clog2(TABLE_ENTRIES);
  localparam int NV_W = VAL_W + 1;
  localparam int SLOT_W = VAL_W + 1;
  localparam int SLOTS = 2 ** SLOT_W;
  localparam int KEY_W = 3 * IDX_W;
  localparam int ENTRY_W = vkdi_pkg::EPOCH_W + KEY_W + VAL_W;
  localparam int EXT_W = (IDX_W > vkdi_pkg::CNT_W) ? IDX_W : vkdi_pkg::CNT_W;
  localparam int OVX_W = (VAL_W > vkdi_pkg::OUT_W) ? VAL_W : vkdi_pkg::OUT_W;
  localparam int FOLDS = (KEY_W + SLOT_W - 1) / SLOT_W;

  logic [vkdi_pkg::CNT_W-1:0] position_count;
  logic [vkdi_pkg::CNT_W-1:0] normal_count;
  logic [vkdi_pkg::CNT_W-1:0] texcoord_count;
  logic                       has_normals;
  logic                       has_texcoords;

  logic                       item_start;
  logic [IDX_W-1:0]           item_p;
  logic [IDX_W-1:0]           item_n;
  logic [IDX_W-1:0]           item_t;
  logic [SLOT_W-1:0]          slot;
  logic [vkdi_pkg::EPOCH_W-1:0] epoch;
  logic [SLOT_W-1:0]          sweep_addr;
  logic [NV_W-1:0]            next_vertex;
  logic [vkdi_pkg::ERR_W-1:0] failed_code;
  logic                       hit;
  logic [VAL_W-1:0]           hit_val;

  logic [ENTRY_W-1:0]         mem [SLOTS];
  logic [ENTRY_W-1:0]         rd_data;

  logic [KEY_W-1:0]           in_key;
  logic [KEY_W-1:0]           item_key;
  logic [FOLDS*SLOT_W-1:0]    key_pad;
  logic [SLOT_W-1:0]          in_hash;
  logic [SLOT_W-1:0]          rd_addr;
  logic [vkdi_pkg::EPOCH_W-1:0] rd_epoch;
  logic [KEY_W-1:0]           rd_key;
  logic [VAL_W-1:0]           rd_val;

  logic [EXT_W-1:0]           p_ext;
  logic [EXT_W-1:0]           n_ext;
  logic [EXT_W-1:0]           t_ext;
  logic                       p_ok;
  logic                       n_chk;
  logic                       n_ok;
  logic                       t_chk;
  logic                       t_ok;
  logic [vkdi_pkg::ERR_W-1:0] new_err;
  logic [OVX_W-1:0]           hit_ovx;
  logic [OVX_W-1:0]           new_ovx;

  logic [vkdi_pkg::OUT_W-1:0]   out_vertex_next;
  logic                         is_new_next;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_position_next;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_normal_next;
  logic                         normal_is_zero_next;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_texcoord_next;
  logic                         texcoord_is_zero_next;
  logic [vkdi_pkg::ERR_W-1:0]   error_code_next;

  assign in_key = {position_index, normal_idx, texcoord_idx};
  assign item_key = {item_p, item_n, item_t};

  // The slot is an XOR fold of the whole key.
  always_comb begin
    key_pad = (FOLDS * SLOT_W)'(in_key);
    in_hash = '0;
    for (int c = 0; c < FOLDS; c++) begin
      in_hash = in_hash ^ key_pad[c*SLOT_W +: SLOT_W];
    end
  end

  assign rd_addr = cmd.next ? slot + SLOT_W'(1) : slot;
  assign rd_epoch = rd_data[ENTRY_W-1 -: vkdi_pkg::EPOCH_W];
  assign rd_key = rd_data[VAL_W +: KEY_W];
  assign rd_val = rd_data[VAL_W-1:0];

  assign p_ext = EXT_W'(item_p);
  assign n_ext = EXT_W'(item_n);
  assign t_ext = EXT_W'(item_t);
  assign p_ok = !item_p[IDX_W-1] && (p_ext < EXT_W'(position_count));
  assign n_chk = has_normals && !item_n[IDX_W-1];
  assign n_ok = n_ext < EXT_W'(normal_count);
  assign t_chk = has_texcoords && !item_t[IDX_W-1];
  assign t_ok = t_ext < EXT_W'(texcoord_count);
  assign hit_ovx = OVX_W'(hit_val);
  assign new_ovx = OVX_W'(next_vertex[VAL_W-1:0]);

  always_comb begin
    if (!p_ok) begin
      new_err = vkdi_pkg::ERR_POSITION;
    end else if (n_chk && !n_ok) begin
      new_err = vkdi_pkg::ERR_NORMAL;
    end else if (t_chk && !t_ok) begin
      new_err = vkdi_pkg::ERR_TEXCOORD;
    end else if (next_vertex >= NV_W'(TABLE_ENTRIES)) begin
      new_err = vkdi_pkg::ERR_FULL;
    end else begin
      new_err = vkdi_pkg::ERR_NONE;
    end
  end

  always_comb begin
    status.start = item_start;
    status.failed = (failed_code != vkdi_pkg::ERR_NONE);
    status.epoch_last = (epoch == vkdi_pkg::EPOCH_LAST);
    status.sweep_last = &sweep_addr;
    status.slot_live = (rd_epoch == epoch);
    status.slot_match = (rd_epoch == epoch) && (rd_key == item_key);
    status.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      normal_count <= '0;
      texcoord_count <= '0;
      has_normals <= 1'b0;
      has_texcoords <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vkdi_pkg::REG_POSITION_COUNT: position_count <= cfg_data;
        vkdi_pkg::REG_NORMAL_COUNT: normal_count <= cfg_data;
        vkdi_pkg::REG_TEXCOORD_COUNT: texcoord_count <= cfg_data;
        vkdi_pkg::REG_HAS_NORMALS: has_normals <= cfg_data[0];
        vkdi_pkg::REG_HAS_TEXCOORDS: has_texcoords <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_start <= start_mesh;
      item_p <= position_index;
      item_n <= normal_idx;
      item_t <= texcoord_idx;
    end
    if (cmd.load) begin
      slot <= in_hash;
    end else if (cmd.next) begin
      slot <= rd_addr;
    end
    if (cmd.resolve) begin
      hit <= status.slot_match;
      hit_val <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= vkdi_pkg::EPOCH_FIRST;
      sweep_addr <= '0;
      next_vertex <= '0;
      failed_code <= vkdi_pkg::ERR_NONE;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + SLOT_W'(1);
      end
      if (cmd.clear) begin
        next_vertex <= '0;
        failed_code <= vkdi_pkg::ERR_NONE;
        epoch <= status.epoch_last ? vkdi_pkg::EPOCH_FIRST : epoch + vkdi_pkg::EPOCH_W'(1);
      end else if (cmd.finish && !status.failed && !hit) begin
        if (new_err != vkdi_pkg::ERR_NONE) begin
          failed_code <= new_err;
        end else begin
          next_vertex <= next_vertex + NV_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr] <= '0;
    end else if (cmd.finish && !status.failed && !hit && new_err == vkdi_pkg::ERR_NONE) begin
      mem[slot] <= {epoch, item_key, next_vertex[VAL_W-1:0]};
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_vertex_next = '0;
    is_new_next = 1'b0;
    fetch_position_next = '0;
    fetch_normal_next = '0;
    normal_is_zero_next = 1'b0;
    fetch_texcoord_next = '0;
    texcoord_is_zero_next = 1'b0;
    error_code_next = vkdi_pkg::ERR_NONE;
    if (status.failed) begin
      error_code_next = failed_code;
    end else if (hit) begin
      out_vertex_next = hit_ovx[vkdi_pkg::OUT_W-1:0];
    end else if (new_err != vkdi_pkg::ERR_NONE) begin
      error_code_next = new_err;
    end else begin
      out_vertex_next = new_ovx[vkdi_pkg::OUT_W-1:0];
      is_new_next = 1'b1;
      fetch_position_next = p_ext[vkdi_pkg::FETCH_W-1:0];
      fetch_normal_next = n_chk ? n_ext[vkdi_pkg::FETCH_W-1:0] : '0;
      normal_is_zero_next = !n_chk;
      fetch_texcoord_next = t_chk ? t_ext[vkdi_pkg::FETCH_W-1:0] : '0;
      texcoord_is_zero_next = !t_chk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_vertex <= out_vertex_next;
      is_new <= is_new_next;
      fetch_position <= fetch_position_next;
      fetch_normal <= fetch_normal_next;
      normal_is_zero <= normal_is_zero_next;
      fetch_texcoord <= fetch_texcoord_next;
      texcoord_is_zero <= texcoord_is_zero_next;
      error_code <= error_code_next;
    end
  end

endmodule

>>> src/vkdi_checker.sv
module vkdi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [vkdi_pkg::OUT_W-1:0]   out_vertex,
  input logic                         is_new,
  input logic [vkdi_pkg::FETCH_W-1:0] fetch_position,
  input logic [vkdi_pkg::FETCH_W-1:0] fetch_normal,
  input logic                         normal_is_zero,
  input logic [vkdi_pkg::FETCH_W-1:0] fetch_texcoord,
  input logic                         texcoord_is_zero,
  input logic [vkdi_pkg::ERR_W-1:0]   error_code
);

  // A stalled result transaction stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // An error result carries no vertex, no new flag and no position fetch.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != vkdi_pkg::ERR_NONE |->
      !is_new && out_vertex == '0 && fetch_position == '0)
    else $error("error result carries payload");

  // A new vertex is never reported together with an error.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> error_code == vkdi_pkg::ERR_NONE)
    else $error("new vertex flagged with an error");

  // Repeats and errors request no attribute fetch.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_new |->
      fetch_position == '0 && fetch_normal == '0 && fetch_texcoord == '0 &&
      !normal_is_zero && !texcoord_is_zero)
    else $error("fetch fields set on a result that is not new");

endmodule

bind vertex_key_dedup_indexer_top vkdi_checker u_vkdi_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_vertex       (out_vertex),
  .is_new           (is_new),
  .fetch_position   (fetch_position),
  .fetch_normal     (fetch_normal),
  .normal_is_zero   (normal_is_zero),
  .fetch_texcoord   (fetch_texcoord),
  .texcoord_is_zero (texcoord_is_zero),
  .error_code       (error_code)
);

>>> tb/sv/vertex_key_dedup_indexer_top_test.sv
module vertex_key_dedup_indexer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 4096;
  localparam int SOURCE_INDEX_BITS = 24;
  localparam logic [24:0] NO_INDEX = '1;
  localparam logic [24:0] TOP_INDEX = 25'hFFFFFF;
  localparam int unsigned COUNT_MAX = 32'h1000000;
  localparam int RANDOM_CORNERS = 1200;

  typedef struct packed {
    logic [vkdi_pkg::OUT_W-1:0] out_vertex;
    logic is_new;
    logic [vkdi_pkg::FETCH_W-1:0] fetch_position;
    logic [vkdi_pkg::FETCH_W-1:0] fetch_normal;
    logic normal_is_zero;
    logic [vkdi_pkg::FETCH_W-1:0] fetch_texcoord;
    logic texcoord_is_zero;
    logic [vkdi_pkg::ERR_W-1:0] error_code;
  } corner_answer_t;

  typedef struct packed {
    logic [24:0] pos;
    logic [24:0] nrm;
    logic [24:0] tex;
  } corner_t;

  class dedup_scoreboard;
    int unsigned pos_count;
    int unsigned norm_count;
    int unsigned tex_count;
    bit norm_on;
    bit tex_on;
    int unsigned vertex_of[string];
    int unsigned next_vertex;
    logic [vkdi_pkg::ERR_W-1:0] sticky_code;
    corner_answer_t awaited[$];
    int unsigned mismatches;
    int unsigned answers_checked;
    int unsigned new_answers;
    int unsigned repeat_answers;
    int unsigned error_answers;

    function void set_reg(logic [vkdi_pkg::CFG_IDX_W-1:0] idx,
                          logic [vkdi_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        vkdi_pkg::REG_POSITION_COUNT: pos_count = 32'(value);
        vkdi_pkg::REG_NORMAL_COUNT: norm_count = 32'(value);
        vkdi_pkg::REG_TEXCOORD_COUNT: tex_count = 32'(value);
        vkdi_pkg::REG_HAS_NORMALS: norm_on = value[0];
        vkdi_pkg::REG_HAS_TEXCOORDS: tex_on = value[0];
        default: ;
      endcase
    endfunction

    function bit fits(logic [24:0] v, int unsigned count);
      return !v[24] && (32'(v) < count);
    endfunction

    function void note_corner(bit start, corner_t c);
      corner_answer_t r;
      string key;
      logic [vkdi_pkg::ERR_W-1:0] code;
      r = '0;
      key = $sformatf("%h_%h_%h", c.pos, c.nrm, c.tex);
      if (start) begin
        vertex_of.delete();
        next_vertex = 0;
        sticky_code = vkdi_pkg::ERR_NONE;
      end
      if (sticky_code != vkdi_pkg::ERR_NONE) begin
        r.error_code = sticky_code;
      end else if (vertex_of.exists(key)) begin
        r.out_vertex = vkdi_pkg::OUT_W'(vertex_of[key]);
      end else begin
        code = vkdi_pkg::ERR_NONE;
        r.normal_is_zero = 1'b1;
        r.texcoord_is_zero = 1'b1;
        if (!fits(c.pos, pos_count)) begin
          code = vkdi_pkg::ERR_POSITION;
        end else begin
          if (norm_on && !c.nrm[24]) begin
            if (!fits(c.nrm, norm_count)) begin
              code = vkdi_pkg::ERR_NORMAL;
            end else begin
              r.fetch_normal = c.nrm[23:0];
              r.normal_is_zero = 1'b0;
            end
          end
          if (code == vkdi_pkg::ERR_NONE && tex_on && !c.tex[24]) begin
            if (!fits(c.tex, tex_count)) begin
              code = vkdi_pkg::ERR_TEXCOORD;
            end else begin
              r.fetch_texcoord = c.tex[23:0];
              r.texcoord_is_zero = 1'b0;
            end
          end
          if (code == vkdi_pkg::ERR_NONE && next_vertex >= TABLE_ENTRIES)
            code = vkdi_pkg::ERR_FULL;
        end
        if (code != vkdi_pkg::ERR_NONE) begin
          sticky_code = code;
          r = '0;
          r.error_code = code;
        end else begin
          vertex_of[key] = next_vertex;
          r.out_vertex = vkdi_pkg::OUT_W'(next_vertex);
          r.is_new = 1'b1;
          r.fetch_position = c.pos[23:0];
          next_vertex++;
        end
      end
      awaited.insert(awaited.size(), r);
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0d ns: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(corner_answer_t got);
      corner_answer_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0d ns: result with nothing expected, got vertex %0h error %0h",
                   $time, got.out_vertex, got.error_code);
        return;
      end
      want = awaited.pop_front();
      answers_checked++;
      if (want.error_code != vkdi_pkg::ERR_NONE) error_answers++;
      else if (want.is_new) new_answers++;
      else repeat_answers++;
      compare_field("out_vertex", 24'(want.out_vertex), 24'(got.out_vertex));
      compare_field("is_new", 24'(want.is_new), 24'(got.is_new));
      compare_field("fetch_position", want.fetch_position, got.fetch_position);
      compare_field("fetch_normal", want.fetch_normal, got.fetch_normal);
      compare_field("normal_is_zero", 24'(want.normal_is_zero), 24'(got.normal_is_zero));
      compare_field("fetch_texcoord", want.fetch_texcoord, got.fetch_texcoord);
      compare_field("texcoord_is_zero", 24'(want.texcoord_is_zero),
                    24'(got.texcoord_is_zero));
      compare_field("error_code", 24'(want.error_code), 24'(got.error_code));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic start_mesh;
  logic signed [SOURCE_INDEX_BITS:0] position_index;
  logic signed [SOURCE_INDEX_BITS:0] normal_idx;
  logic signed [SOURCE_INDEX_BITS:0] texcoord_idx;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [vkdi_pkg::OUT_W-1:0] out_vertex;
  logic is_new;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_position;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_normal;
  logic normal_is_zero;
  logic [vkdi_pkg::FETCH_W-1:0] fetch_texcoord;
  logic texcoord_is_zero;
  logic [vkdi_pkg::ERR_W-1:0] error_code;
  logic cfg_we;
  logic [vkdi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vkdi_pkg::CFG_DATA_W-1:0] cfg_data;

  bit tx_idling = 1'b0;
  bit rx_idling = 1'b0;
  int unsigned stall_left = 0;
  int unsigned corners_sent;
  int unsigned mesh_starts;
  int unsigned cur_pos_count;
  int unsigned cur_norm_count;
  int unsigned cur_tex_count;
  dedup_scoreboard sb;

  vertex_key_dedup_indexer_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SOURCE_INDEX_BITS(SOURCE_INDEX_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_mesh(start_mesh),
    .position_index(position_index),
    .normal_idx(normal_idx),
    .texcoord_idx(texcoord_idx),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_vertex(out_vertex),
    .is_new(is_new),
    .fetch_position(fetch_position),
    .fetch_normal(fetch_normal),
    .normal_is_zero(normal_is_zero),
    .fetch_texcoord(fetch_texcoord),
    .texcoord_is_zero(texcoord_is_zero),
    .error_code(error_code),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rx_idling) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : collect
    corner_answer_t got;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got.out_vertex = out_vertex;
      got.is_new = is_new;
      got.fetch_position = fetch_position;
      got.fetch_normal = fetch_normal;
      got.normal_is_zero = normal_is_zero;
      got.fetch_texcoord = fetch_texcoord;
      got.texcoord_is_zero = texcoord_is_zero;
      got.error_code = error_code;
      sb.check_result(got);
    end
  end

  task automatic write_reg(logic [vkdi_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= vkdi_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_reg(idx, vkdi_pkg::CFG_DATA_W'(value));
  endtask

  task automatic set_config(int unsigned pc, int unsigned nc, int unsigned tc, bit hn, bit ht);
    write_reg(vkdi_pkg::REG_POSITION_COUNT, pc);
    write_reg(vkdi_pkg::REG_NORMAL_COUNT, nc);
    write_reg(vkdi_pkg::REG_TEXCOORD_COUNT, tc);
    write_reg(vkdi_pkg::REG_HAS_NORMALS, 32'(hn));
    write_reg(vkdi_pkg::REG_HAS_TEXCOORDS, 32'(ht));
    cfg_we <= 1'b0;
    cur_pos_count = pc;
    cur_norm_count = nc;
    cur_tex_count = tc;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_corner(bit start, corner_t c);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_mesh <= start;
    position_index <= c.pos;
    normal_idx <= c.nrm;
    texcoord_idx <= c.tex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_corner(start, c);
    corners_sent++;
    if (start) mesh_starts++;
  endtask

  function automatic logic [24:0] pick_index(int unsigned count, int unsigned neg_pm,
                                             int unsigned bad_pm);
    int unsigned roll;
    roll = $urandom_range(0, 999);
    if (roll < neg_pm) return NO_INDEX;
    if (roll < neg_pm + bad_pm || count == 0) begin
      if (count <= 32'hFFFFFF) return 25'($urandom_range(count, 32'hFFFFFF));
      return NO_INDEX;
    end
    if ($urandom_range(0, 9) == 0) return 25'(count - 1);
    return 25'($urandom_range(0, count - 1));
  endfunction

  function automatic int unsigned pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll < 7) return $urandom_range(1, 64);
    if (roll < 11) return $urandom_range(65, 4096);
    if (roll < 15) return COUNT_MAX;
    return $urandom_range(1, COUNT_MAX);
  endfunction

  task automatic run_mesh(int unsigned len);
    corner_t seen_corners[$];
    corner_t c;
    for (int unsigned i = 0; i < len; i++) begin
      if (seen_corners.size() != 0 && $urandom_range(0, 99) < 45) begin
        c = seen_corners[$urandom_range(0, seen_corners.size() - 1)];
      end else begin
        c.pos = pick_index(cur_pos_count, 5, 10);
        c.nrm = pick_index(cur_norm_count, 150, 8);
        c.tex = pick_index(cur_tex_count, 150, 8);
        seen_corners.insert(seen_corners.size(), c);
      end
      send_corner(i == 0, c);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    start_mesh = 1'b0;
    position_index = '0;
    normal_idx = '0;
    texcoord_idx = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    corners_sent = 0;
    mesh_starts = 0;
    sb = new;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_config(16, 8, 8, 1'b1, 1'b1);
    send_corner(1'b1, '{pos: 25'd0, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b0, '{pos: 25'd0, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b0, '{pos: 25'd15, nrm: 25'd7, tex: 25'd7});
    send_corner(1'b0, '{pos: 25'd3, nrm: NO_INDEX, tex: NO_INDEX});
    send_corner(1'b0, '{pos: 25'd3, nrm: NO_INDEX, tex: NO_INDEX});
    send_corner(1'b0, '{pos: 25'd3, nrm: 25'd7, tex: NO_INDEX});
    send_corner(1'b0, '{pos: 25'd4, nrm: 25'd8, tex: 25'd0});
    send_corner(1'b0, '{pos: 25'd0, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b1, '{pos: 25'd5, nrm: 25'd1, tex: 25'd8});
    send_corner(1'b0, '{pos: 25'd1, nrm: 25'd1, tex: 25'd1});
    send_corner(1'b1, '{pos: 25'd16, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b1, '{pos: NO_INDEX, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b1, '{pos: TOP_INDEX, nrm: 25'd0, tex: 25'd0});
    send_corner(1'b1, '{pos: 25'd2, nrm: TOP_INDEX, tex: 25'd0});
    send_corner(1'b1, '{pos: 25'd2, nrm: 25'd3, tex: TOP_INDEX});
    send_corner(1'b1, '{pos: 25'd7, nrm: NO_INDEX, tex: 25'd5});
    send_corner(1'b0, '{pos: 25'd7, nrm: NO_INDEX, tex: 25'd5});
    drain();

    set_config(COUNT_MAX, 0, 0, 1'b0, 1'b0);
    send_corner(1'b1, '{pos: TOP_INDEX, nrm: TOP_INDEX, tex: TOP_INDEX});
    send_corner(1'b0, '{pos: TOP_INDEX, nrm: NO_INDEX, tex: TOP_INDEX});
    send_corner(1'b0, '{pos: TOP_INDEX, nrm: TOP_INDEX, tex: TOP_INDEX});
    send_corner(1'b0, '{pos: 25'd0, nrm: 25'd12345, tex: NO_INDEX});
    drain();

    set_config(COUNT_MAX, 0, 0, 1'b1, 1'b1);
    send_corner(1'b1, '{pos: 25'd1, nrm: NO_INDEX, tex: NO_INDEX});
    send_corner(1'b0, '{pos: 25'd1, nrm: 25'd0, tex: NO_INDEX});
    send_corner(1'b1, '{pos: 25'd2, nrm: NO_INDEX, tex: 25'd0});
    send_corner(1'b1, '{pos: 25'd5, nrm: NO_INDEX, tex: NO_INDEX});
    drain();

    corners_sent = 0;
    while (corners_sent < RANDOM_CORNERS) begin
      drain();
      set_config(pick_count(), pick_count(), pick_count(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      if (corners_sent + 200 >= RANDOM_CORNERS) begin
        tx_idling <= 1'b0;
        rx_idling <= 1'b0;
      end else begin
        tx_idling <= ($urandom_range(0, 3) != 0);
        rx_idling <= ($urandom_range(0, 3) != 0);
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0) run_mesh($urandom_range(1, 3));
        else run_mesh($urandom_range(4, 60));
      end
    end

    drain();
    tx_idling <= 1'b0;
    rx_idling <= 1'b0;
    repeat (20) @(posedge clk);

    $display("Checked %0d results over %0d mesh starts under random counts and stalls.",
             sb.answers_checked, mesh_starts);
    $display("Answers: %0d new vertices, %0d repeated corners, %0d error codes.",
             sb.new_answers, sb.repeat_answers, sb.error_answers);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("vertex_key_dedup_indexer_top_test OK");
    end else begin
      $display("vertex_key_dedup_indexer_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results outstanding.", sb.awaited.size());
    $display("vertex_key_dedup_indexer_top_test NOT OK");
    $finish;
  end

endmodule

>>> vertex_key_dedup_indexer_top.f
src/vkdi_pkg.sv
src/vkdi_ctrl.sv
src/vkdi_datapath.sv
src/vertex_key_dedup_indexer_top.sv
src/vkdi_checker.sv
tb/sv/vertex_key_dedup_indexer_top_test.sv
